>>> rtl/rdrs_pkg.sv
package rdrs_pkg;

  localparam int IN_W     = 10;
  localparam int RATE_W   = 9;
  localparam int RATE_MAX = 256;
  localparam int SLOW_LIM = 30;
  localparam int SMALL_LIM = 10;

  // Bits of quotient resolved per divider pipeline stage.
  localparam int DIV_BPS = 4;

  localparam int NEED_W = 13;
  localparam int BW_N   = 8;
  localparam logic [NEED_W-1:0] BW_LIMIT [BW_N] = '{
    13'd322, 13'd3355, 13'd3618, 13'd4202, 13'd4684, 13'd5188, 13'd5770, 13'd6207
  };
  localparam logic [7:0] BW_CODE [BW_N] = '{
    8'h26, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E
  };
  localparam logic [7:0] CODE_NONE = 8'hFF;

  localparam logic [7:0] MOD_MANCH   = 8'h26;
  localparam logic [7:0] MOD_PLAIN   = 8'h06;
  localparam logic [7:0] DEV_CODE_LO = 8'd24;
  localparam logic [7:0] DEV_CODE_HI = 8'd240;
  localparam logic [7:0] DEV_KHZ_LO  = 8'd15;
  localparam logic [7:0] DEV_KHZ_HI  = 8'd150;

  // Divider geometry: numerator and denominator widths.
  localparam int OVS_NW  = 17;
  localparam int OVS_DW  = 17;
  localparam int GAIN_NW = 25;
  localparam int GAIN_DW = 25;

  localparam int OVS_LAT  = (OVS_NW + DIV_BPS - 1) / DIV_BPS;
  localparam int GAIN_LAT = (GAIN_NW + DIV_BPS - 1) / DIV_BPS;
  localparam int DIV_LAT  = OVS_LAT + 1 + GAIN_LAT;

  // Constant divisions use a multiply by ceil(2^RCP_SH / d) followed by a shift.
  localparam int RCP_SH = 36;

  localparam int NCO_NW = 27;
  localparam int NCO_RW = 30;
  localparam int NCO_PW = NCO_NW + NCO_RW;
  localparam logic [NCO_NW-1:0] NCO_DEN_LO = 27'd125;
  localparam logic [NCO_NW-1:0] NCO_DEN_HI = 27'd375;
  localparam logic [NCO_RW-1:0] NCO_RCP_LO = 30'd549755814;
  localparam logic [NCO_RW-1:0] NCO_RCP_HI = 30'd183251938;

  localparam int DRW_NW = 26;
  localparam int DRW_RW = 27;
  localparam int DRW_PW = DRW_NW + DRW_RW;
  localparam logic [DRW_RW-1:0] DRW_RCP = 27'd68719477;

  localparam int DRW_SH_SLOW = 21;
  localparam int DRW_SH_FAST = 16;
  localparam int NCO_SH_BASE = 18;

  localparam logic [10:0] GAIN_MAX = 11'h7FF;

  typedef struct packed {
    logic              acc;
    logic              slow;
    logic              small_dev;
    logic [RATE_W-1:0] rate;
    logic [7:0]        code;
  } side_t;

endpackage

>>> rtl/rdrs_delay.sv
module rdrs_delay
  import rdrs_pkg::*;
#(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (DEPTH == 0) begin : g_pass
    assign q_o = d_i;
  end else begin : g_line
    logic [W-1:0] line_q [DEPTH];

    always_ff @(posedge clk_i) begin
      line_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end

    assign q_o = line_q[DEPTH-1];
  end

endmodule

>>> rtl/rdrs_div.sv
module rdrs_div
  import rdrs_pkg::*;
#(
  parameter int NW  = 17,
  parameter int DW  = 17,
  parameter int BPS = 4
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quot_o
);

  localparam int NS = (NW + BPS - 1) / BPS;
  localparam int PW = NS * BPS;

  // The numerator shifts out at the top while quotient bits shift in at the bottom.
  logic [PW-1:0] nq_q  [NS];
  logic [DW-1:0] rem_q [NS-1];
  logic [DW-1:0] den_q [NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [PW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW-1:0] rem_d;
    logic [PW-1:0] nq_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = PW'(num_i);
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      logic [DW:0] t;
      rem_d = rem_in;
      nq_d  = nq_in;
      for (int j = 0; j < BPS; j++) begin
        t = {rem_d, nq_d[PW-1]};
        if (t >= {1'b0, den_in}) begin
          rem_d = DW'(t - {1'b0, den_in});
          nq_d  = {nq_d[PW-2:0], 1'b1};
        end else begin
          rem_d = t[DW-1:0];
          nq_d  = {nq_d[PW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      nq_q[k] <= nq_d;
    end

    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quot_o = nq_q[NS-1][NW-1:0];

endmodule

>>> rtl/radio_data_rate_settings_top.sv
// Path from a start beat to the output ports: three decode stages,
// 5-stage oversampling divider, one multiply stage, 7-stage gain divider,
// output register; each divider resolves 4 quotient bits a stage.
// Throughput: one rate per cycle; busy_o stays low and the receiver cannot stall.
// Reset clears only the valid pipeline; result payload registers are not reset.
module radio_data_rate_settings_top
  import rdrs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [IN_W-1:0] data_rate_kbps_i,
  output logic            done_o,
  output logic            accepted_o,
  output logic [7:0]      mod_control1_o,
  output logic [7:0]      deviation_code_o,
  output logic [15:0]     data_rate_word_o,
  output logic [7:0]      if_filter_code_o,
  output logic [10:0]     oversampling_ratio_o,
  output logic [19:0]     nco_offset_o,
  output logic [10:0]     recovery_gain_o
);

  localparam int VLEN = 3 + DIV_LAT + 1;

  assign busy_o = 1'b0;

  logic [VLEN-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLEN-2:0], start_i};
    end
  end

  assign done_o = vld_q[VLEN-1];

  // Stage 1: range check and filter bandwidth requirement.
  side_t             side1_d, side1_q;
  logic [NEED_W-1:0] need1_d, need1_q;
  logic [IN_W-1:0]   span;

  always_comb begin
    side1_d.acc       = (data_rate_kbps_i != '0) && (data_rate_kbps_i <= IN_W'(RATE_MAX));
    side1_d.slow      = data_rate_kbps_i < IN_W'(SLOW_LIM);
    side1_d.small_dev = data_rate_kbps_i <= IN_W'(SMALL_LIM);
    side1_d.rate      = data_rate_kbps_i[RATE_W-1:0];
    side1_d.code      = '0;
    span    = (side1_d.small_dev ? IN_W'(30) : IN_W'(300)) + IN_W'(side1_d.rate);
    need1_d = (NEED_W'(span) << 3) + (NEED_W'(span) << 1);
  end

  always_ff @(posedge clk_i) begin
    side1_q <= side1_d;
    need1_q <= need1_d;
  end

  // Stage 2: narrowest covering filter.
  side_t side2_d, side2_q;

  always_comb begin
    side2_d      = side1_q;
    side2_d.code = CODE_NONE;
    for (int i = BW_N - 1; i >= 0; i--) begin
      if (BW_LIMIT[i] >= need1_q) begin
        side2_d.code = BW_CODE[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
  end

  // Stage 3: divider operands.
  side_t              side3_q;
  logic [OVS_NW-1:0]  ovs_num_d, ovs_num_q;
  logic [OVS_DW-1:0]  ovs_den_d, ovs_den_q;
  logic [NCO_NW-1:0]  nco_num_d, nco_num_q;
  logic [NCO_RW-1:0]  nco_rcp_d, nco_rcp_q;
  logic [DRW_NW-1:0]  drw_num_d, drw_num_q;
  logic               bypass;
  logic [2:0]         dec_exp;
  logic [15:0]        ovs_div;

  always_comb begin
    bypass    = side2_q.code[7];
    dec_exp   = side2_q.code[6:4];
    ovs_div   = 16'(side2_q.rate) << dec_exp;
    // Round to nearest: (2n + d) / (2d).
    ovs_num_d = (bypass ? OVS_NW'(24000) : OVS_NW'(8000)) + OVS_NW'(ovs_div);
    ovs_den_d = {ovs_div, 1'b0};
    nco_rcp_d = bypass ? NCO_RCP_HI : NCO_RCP_LO;
    // Ceiling: (n + d - 1) / d, with 2^20 / 500 and 2^20 / 1500 reduced to 2^18 / 125 and 2^18 / 375.
    nco_num_d = (NCO_NW'(side2_q.rate) << (NCO_SH_BASE + int'(dec_exp)))
              + (bypass ? NCO_DEN_HI : NCO_DEN_LO) - NCO_NW'(1);
    drw_num_d = (DRW_NW'(side2_q.rate) << (side2_q.slow ? DRW_SH_SLOW : DRW_SH_FAST))
              + DRW_NW'(500);
  end

  always_ff @(posedge clk_i) begin
    side3_q   <= side2_q;
    ovs_num_q <= ovs_num_d;
    ovs_den_q <= ovs_den_d;
    nco_num_q <= nco_num_d;
    nco_rcp_q <= nco_rcp_d;
    drw_num_q <= drw_num_d;
  end

  logic [OVS_NW-1:0] ovs_quot;

  rdrs_div #(.NW(OVS_NW), .DW(OVS_DW), .BPS(DIV_BPS)) u_ovs_div (
    .clk_i  (clk_i),
    .num_i  (ovs_num_q),
    .den_i  (ovs_den_q),
    .quot_o (ovs_quot)
  );

  // The reciprocal error stays below one divisor step over the operand range,
  // so the shifted product is the exact floor of the quotient.
  logic [NCO_PW-1:0] nco_prod_q;
  logic [DRW_PW-1:0] drw_prod_q;

  always_ff @(posedge clk_i) begin
    nco_prod_q <= NCO_PW'(nco_num_q) * NCO_PW'(nco_rcp_q);
    drw_prod_q <= DRW_PW'(drw_num_q) * DRW_PW'(DRW_RCP);
  end

  side_t side_o;

  rdrs_delay #(.W($bits(side_t)), .DEPTH(OVS_LAT)) u_side_dly (
    .clk_i (clk_i),
    .d_i   (side3_q),
    .q_o   (side_o)
  );

  // Multiply stage: gain operands.
  side_t              side_m_q;
  logic [OVS_NW-1:0]  ovs_m_q;
  logic [GAIN_NW-1:0] gnum_m_q;
  logic [GAIN_DW-1:0] gden_m_q;

  always_ff @(posedge clk_i) begin
    side_m_q <= side_o;
    ovs_m_q  <= ovs_quot;
    gnum_m_q <= (GAIN_NW'(side_o.rate) << 16) - GAIN_NW'(side_o.rate);
    gden_m_q <= GAIN_DW'(ovs_quot)
              * GAIN_DW'(side_o.small_dev ? DEV_KHZ_LO : DEV_KHZ_HI);
  end

  logic [GAIN_NW-1:0] gain_quot;

  rdrs_div #(.NW(GAIN_NW), .DW(GAIN_DW), .BPS(DIV_BPS)) u_gain_div (
    .clk_i  (clk_i),
    .num_i  (gnum_m_q),
    .den_i  (gden_m_q),
    .quot_o (gain_quot)
  );

  side_t       side_f;
  logic [10:0] ovs_f;
  logic [19:0] nco_f;
  logic [15:0] drw_f;

  rdrs_delay #(.W($bits(side_t)), .DEPTH(GAIN_LAT)) u_side_m_dly (
    .clk_i (clk_i),
    .d_i   (side_m_q),
    .q_o   (side_f)
  );

  rdrs_delay #(.W(11), .DEPTH(GAIN_LAT)) u_ovs_dly (
    .clk_i (clk_i),
    .d_i   (ovs_m_q[10:0]),
    .q_o   (ovs_f)
  );

  rdrs_delay #(.W(20), .DEPTH(DIV_LAT - 1)) u_nco_dly (
    .clk_i (clk_i),
    .d_i   (nco_prod_q[RCP_SH+19:RCP_SH]),
    .q_o   (nco_f)
  );

  rdrs_delay #(.W(16), .DEPTH(DIV_LAT - 1)) u_drw_dly (
    .clk_i (clk_i),
    .d_i   (drw_prod_q[RCP_SH+15:RCP_SH]),
    .q_o   (drw_f)
  );

  // Output stage: saturation and zeroing of rejected rates.
  logic [10:0] gain_sat;

  assign gain_sat = (gain_quot >= GAIN_NW'(2046)) ? GAIN_MAX : 11'(gain_quot + GAIN_NW'(2));

  always_ff @(posedge clk_i) begin
    accepted_o <= side_f.acc;
    if (side_f.acc) begin
      mod_control1_o       <= side_f.slow ? MOD_MANCH : MOD_PLAIN;
      deviation_code_o     <= side_f.small_dev ? DEV_CODE_LO : DEV_CODE_HI;
      data_rate_word_o     <= drw_f;
      if_filter_code_o     <= side_f.code;
      oversampling_ratio_o <= ovs_f;
      nco_offset_o         <= nco_f;
      recovery_gain_o      <= gain_sat;
    end else begin
      mod_control1_o       <= '0;
      deviation_code_o     <= '0;
      data_rate_word_o     <= '0;
      if_filter_code_o     <= '0;
      oversampling_ratio_o <= '0;
      nco_offset_o         <= '0;
      recovery_gain_o      <= '0;
    end
  end

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !accepted_o |-> (mod_control1_o == '0 && deviation_code_o == '0 &&
      data_rate_word_o == '0 && if_filter_code_o == '0 && oversampling_ratio_o == '0 &&
      nco_offset_o == '0 && recovery_gain_o == '0))
    else $error("rejected beat carries nonzero fields");

  a_dev_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && accepted_o |-> (deviation_code_o == DEV_CODE_LO ||
      deviation_code_o == DEV_CODE_HI))
    else $error("deviation code out of set");

  a_low_dev_manch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && accepted_o && deviation_code_o == DEV_CODE_LO |-> mod_control1_o == MOD_MANCH)
    else $error("low deviation without Manchester coding");

  a_gain_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && accepted_o |-> recovery_gain_o >= 11'd2)
    else $error("recovery gain below offset");

endmodule
